// ----- hdl/asc_pkg.sv -----
// Shared types and constants for the adaptive slope curb detector.
package asc_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam int OPA_W  = 64;
    localparam int OPB_W  = 36;
    localparam int ACC_W  = 100;
    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(OPB_W);

    localparam logic signed [23:0] SLOPE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SLOPE_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        CFG_SLOPE_LIMIT = 2'd0,
        CFG_DEV_WEIGHT  = 2'd1,
        CFG_DIST_WEIGHT = 2'd2,
        CFG_MIN_POINTS  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOPE_DIV,
        ST_MEAN_MUL,
        ST_MEAN_DIV,
        ST_DEV_MUL,
        ST_DEV_DIV,
        ST_SQ_S,
        ST_SQ_M,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_AB
    } fsm_state_t;

    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [STEP_W-1:0] steps;
    } alu_ctrl_t;

endpackage

// ----- hdl/asc_alu.sv -----
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit per cycle.
module asc_alu (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  asc_pkg::alu_ctrl_t        ctrl,
    input  logic [asc_pkg::OPA_W-1:0] opa,   // multiplicand or divisor
    input  logic [asc_pkg::OPB_W-1:0] opb,   // multiplier or dividend
    output logic                      done,
    output logic [asc_pkg::ACC_W-1:0] prod,
    output logic [asc_pkg::OPB_W-1:0] quot
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [asc_pkg::STEP_W-1:0]  cnt_reg;
    asc_pkg::alu_op_t            op_reg;
    logic [asc_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [asc_pkg::ACC_W-1:0]   mcand_reg, mcand_next;
    logic [asc_pkg::OPB_W-1:0]   mplr_reg, mplr_next;
    logic [asc_pkg::ACC_W-1:0]   trial;
    logic                        ge;

    always_comb begin
        trial      = {acc_reg[asc_pkg::ACC_W-2:0], mplr_reg[asc_pkg::OPB_W-1]};
        ge         = (trial >= mcand_reg);
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        unique case (op_reg)
            asc_pkg::ALU_MUL: begin
                if (mplr_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[asc_pkg::ACC_W-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[asc_pkg::OPB_W-1:1]};
            end
            asc_pkg::ALU_DIV: begin
                acc_next  = ge ? (trial - mcand_reg) : trial;
                mplr_next = {mplr_reg[asc_pkg::OPB_W-2:0], ge};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= asc_pkg::ALU_MUL;
        end else begin
            done_reg <= busy_reg && (cnt_reg == asc_pkg::STEP_W'(1));
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.steps;
                op_reg   <= ctrl.op;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - asc_pkg::STEP_W'(1);
                if (cnt_reg == asc_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            acc_reg   <= '0;
            mcand_reg <= asc_pkg::ACC_W'(opa);
            mplr_reg  <= opb;
        end else if (busy_reg) begin
            acc_reg   <= acc_next;
            mcand_reg <= mcand_next;
            mplr_reg  <= mplr_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign quot = mplr_reg;

endmodule

// ----- hdl/adaptive_slope_curb_detector.sv -----
// Adaptive slope curb detector: sequencer, beam state and the shared multiply/divide unit.
// Output: a first, saturated, ignored or 0/0 point sets the output register in the
//   cycle after its beat; a full update runs the slope divide (not when dr is zero),
//   the mean and deviation updates and, past min_points and under the slope limit,
//   the adaptive test. One point at a time: the next beat is taken the cycle after the result beat.
// Reset: synchronous, active low; config takes defaults, beam and control state clear.
module adaptive_slope_curb_detector #(
    parameter int MAX_POINTS = asc_pkg::MAX_POINTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // radius[17:0], height[33:18], zero pad
    input  logic        s_axis_tuser,   // first_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // is_curb[0], point_index[10:1], zero pad
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    logic signed [23:0] slope_limit_reg;
    logic [15:0]        dev_weight_reg, dist_weight_reg;
    logic [9:0]         min_points_reg;

    asc_pkg::fsm_state_t state_reg, state_next;
    logic               pend_reg, pend_next;

    logic [17:0]        prev_r_reg, prev_r_next;
    logic signed [15:0] prev_h_reg, prev_h_next;
    logic signed [23:0] mean_reg, mean_next;
    logic [24:0]        dev_reg, dev_next;
    logic [9:0]         index_reg, index_next;
    logic [9:0]         invalid_reg, invalid_next;
    logic               edge_reg, edge_next;

    logic signed [16:0] dz_reg, dz_next;
    logic signed [18:0] dr_reg, dr_next;
    logic signed [23:0] s_reg, s_next;
    logic signed [35:0] t_reg, t_next;
    logic [24:0]        diff_reg, diff_next;
    logic [47:0]        s2_reg, s2_next;
    logic signed [48:0] sq_reg, sq_next;
    logic [63:0]        a_reg, a_next;
    logic [34:0]        b_reg, b_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_curb_reg, out_curb_next;
    logic [9:0]         out_idx_reg, out_idx_next;

    asc_pkg::alu_ctrl_t              alu_ctrl;
    logic [asc_pkg::OPA_W-1:0]       alu_opa;
    logic [asc_pkg::OPB_W-1:0]       alu_opb;
    logic                            alu_done;
    logic [asc_pkg::ACC_W-1:0]       alu_prod;
    logic [asc_pkg::OPB_W-1:0]       alu_quot;

    logic               in_first;
    logic [17:0]        in_r;
    logic signed [15:0] in_h;
    logic               s_fire;
    logic signed [16:0] dz_in;
    logic signed [18:0] dr_in;
    logic [9:0]         idx_n;
    logic [16:0]        dz_mag;
    logic [18:0]        dr_mag;
    logic [23:0]        s_mag, mean_mag;
    logic [47:0]        sq_mag;
    logic [9:0]         v_cnt, vm1;
    logic [35:0]        q_sel;
    logic [33:0]        mprod;
    logic signed [23:0] m_new;
    logic signed [24:0] sm_diff;
    logic [asc_pkg::ACC_W-1:0] dev_lim;

    assign in_first = s_axis_tuser;
    assign in_r     = s_axis_tdata[17:0];
    assign in_h     = s_axis_tdata[33:18];

    assign s_axis_tready = (state_reg == asc_pkg::ST_IDLE) && !out_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_idx_reg, out_curb_reg};

    assign dz_in = {in_h[15], in_h} - {prev_h_reg[15], prev_h_reg};
    assign dr_in = {1'b0, in_r} - {1'b0, prev_r_reg};
    assign idx_n = index_reg + 10'd1;

    assign dz_mag   = dz_reg[16] ? (~dz_reg + 17'd1) : dz_reg;
    assign dr_mag   = dr_reg[18] ? (~dr_reg + 19'd1) : dr_reg;
    assign s_mag    = s_reg[23] ? (~s_reg + 24'd1) : s_reg;
    assign mean_mag = mean_reg[23] ? (~mean_reg + 24'd1) : mean_reg;
    assign sq_mag   = sq_reg[48] ? 48'(~sq_reg + 49'd1) : sq_reg[47:0];
    assign v_cnt    = index_reg - invalid_reg;
    assign vm1      = v_cnt - 10'd1;
    assign dev_lim  = asc_pkg::ACC_W'({dev_reg, 32'd0});

    asc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (alu_ctrl),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .done    (alu_done),
        .prod    (alu_prod),
        .quot    (alu_quot)
    );

    always_comb begin
        alu_ctrl.start = pend_reg;
        alu_ctrl.op    = asc_pkg::ALU_MUL;
        alu_ctrl.steps = '0;
        alu_opa        = '0;
        alu_opb        = '0;
        unique case (state_reg)
            asc_pkg::ST_SLOPE_DIV: begin
                alu_ctrl.op    = asc_pkg::ALU_DIV;
                alu_ctrl.steps = asc_pkg::DIV_STEPS;
                alu_opa        = 64'(dr_mag);
                alu_opb        = 36'({dz_mag, 16'd0});
            end
            asc_pkg::ST_MEAN_MUL: begin
                alu_ctrl.steps = 6'd10;
                alu_opa        = 64'(mean_mag);
                alu_opb        = 36'(vm1);
            end
            asc_pkg::ST_MEAN_DIV: begin
                alu_ctrl.op    = asc_pkg::ALU_DIV;
                alu_ctrl.steps = asc_pkg::DIV_STEPS;
                alu_opa        = 64'(v_cnt);
                alu_opb        = t_reg[35] ? 36'(~t_reg + 36'sd1) : 36'(t_reg);
            end
            asc_pkg::ST_DEV_MUL: begin
                alu_ctrl.steps = 6'd10;
                alu_opa        = 64'(dev_reg);
                alu_opb        = 36'(vm1);
            end
            asc_pkg::ST_DEV_DIV: begin
                alu_ctrl.op    = asc_pkg::ALU_DIV;
                alu_ctrl.steps = asc_pkg::DIV_STEPS;
                alu_opa        = 64'(v_cnt);
                alu_opb        = 36'(t_reg);
            end
            asc_pkg::ST_SQ_S: begin
                alu_ctrl.steps = 6'd24;
                alu_opa        = 64'(s_mag);
                alu_opb        = 36'(s_mag);
            end
            asc_pkg::ST_SQ_M: begin
                alu_ctrl.steps = 6'd24;
                alu_opa        = 64'(mean_mag);
                alu_opb        = 36'(mean_mag);
            end
            asc_pkg::ST_MUL_A: begin
                alu_ctrl.steps = 6'd16;
                alu_opa        = 64'(sq_mag);
                alu_opb        = 36'(dev_weight_reg);
            end
            asc_pkg::ST_MUL_B: begin
                alu_ctrl.steps = 6'd16;
                alu_opa        = 64'(dr_mag);
                alu_opb        = 36'(dist_weight_reg);
            end
            asc_pkg::ST_MUL_AB: begin
                alu_ctrl.steps = 6'd35;
                alu_opa        = a_reg;
                alu_opb        = 36'(b_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        pend_next      = 1'b0;
        prev_r_next    = prev_r_reg;
        prev_h_next    = prev_h_reg;
        mean_next      = mean_reg;
        dev_next       = dev_reg;
        index_next     = index_reg;
        invalid_next   = invalid_reg;
        edge_next      = edge_reg;
        dz_next        = dz_reg;
        dr_next        = dr_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        diff_next      = diff_reg;
        s2_next        = s2_reg;
        sq_next        = sq_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_curb_next  = out_curb_reg;
        out_idx_next   = out_idx_reg;
        q_sel          = alu_quot;
        mprod          = alu_prod[33:0];
        m_new          = t_reg[35] ? (~q_sel[23:0] + 24'd1) : q_sel[23:0];
        sm_diff        = {s_reg[23], s_reg} - {m_new[23], m_new};

        unique case (state_reg)
            asc_pkg::ST_IDLE: begin
                if (s_fire) begin
                    out_curb_next = 1'b0;
                    if (in_first) begin
                        prev_r_next    = in_r;
                        prev_h_next    = in_h;
                        mean_next      = '0;
                        dev_next       = '0;
                        index_next     = '0;
                        invalid_next   = '0;
                        edge_next      = 1'b0;
                        out_idx_next   = '0;
                        out_valid_next = 1'b1;
                    end else if (index_reg == 10'h3FF) begin
                        out_idx_next   = 10'h3FF;
                        out_valid_next = 1'b1;
                    end else begin
                        index_next   = idx_n;
                        out_idx_next = idx_n;
                        if (edge_reg || (32'(idx_n) >= 32'(MAX_POINTS))) begin
                            out_valid_next = 1'b1;
                        end else begin
                            prev_r_next = in_r;
                            prev_h_next = in_h;
                            dz_next     = dz_in;
                            dr_next     = dr_in;
                            if (dr_in == 19'sd0) begin
                                if (dz_in == 17'sd0) begin
                                    invalid_next   = invalid_reg + 10'd1;
                                    out_valid_next = 1'b1;
                                end else begin
                                    s_next     = dz_in[16] ? asc_pkg::SLOPE_MIN
                                                           : asc_pkg::SLOPE_MAX;
                                    state_next = asc_pkg::ST_MEAN_MUL;
                                    pend_next  = 1'b1;
                                end
                            end else begin
                                state_next = asc_pkg::ST_SLOPE_DIV;
                                pend_next  = 1'b1;
                            end
                        end
                    end
                end
            end
            asc_pkg::ST_SLOPE_DIV: begin
                if (alu_done) begin
                    if (dz_reg[16] ^ dr_reg[18]) begin
                        s_next = (q_sel > 36'd8388608) ? asc_pkg::SLOPE_MIN
                                                       : (~q_sel[23:0] + 24'd1);
                    end else begin
                        s_next = (q_sel > 36'd8388607) ? asc_pkg::SLOPE_MAX
                                                       : q_sel[23:0];
                    end
                    state_next = asc_pkg::ST_MEAN_MUL;
                    pend_next  = 1'b1;
                end
            end
            asc_pkg::ST_MEAN_MUL: begin
                if (alu_done) begin
                    t_next = (mean_reg[23] ? (~{2'b0, mprod} + 36'sd1) : {2'b0, mprod})
                             + 36'(s_reg);
                    state_next = asc_pkg::ST_MEAN_DIV;
                    pend_next  = 1'b1;
                end
            end
            asc_pkg::ST_MEAN_DIV: begin
                if (alu_done) begin
                    mean_next  = m_new;
                    diff_next  = sm_diff[24] ? 25'(~sm_diff + 25'sd1) : 25'(sm_diff);
                    state_next = asc_pkg::ST_DEV_MUL;
                    pend_next  = 1'b1;
                end
            end
            asc_pkg::ST_DEV_MUL: begin
                if (alu_done) begin
                    t_next     = {1'b0, alu_prod[34:0]} + 36'(diff_reg);
                    state_next = asc_pkg::ST_DEV_DIV;
                    pend_next  = 1'b1;
                end
            end
            asc_pkg::ST_DEV_DIV: begin
                if (alu_done) begin
                    dev_next = q_sel[24:0];
                    if (s_reg > slope_limit_reg) begin
                        edge_next      = 1'b1;
                        out_curb_next  = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = asc_pkg::ST_IDLE;
                    end else if (index_reg > min_points_reg) begin
                        state_next = asc_pkg::ST_SQ_S;
                        pend_next  = 1'b1;
                    end else begin
                        out_valid_next = 1'b1;
                        state_next     = asc_pkg::ST_IDLE;
                    end
                end
            end
            asc_pkg::ST_SQ_S: begin
                if (alu_done) begin
                    s2_next    = alu_prod[47:0];
                    state_next = asc_pkg::ST_SQ_M;
                    pend_next  = 1'b1;
                end
            end
            asc_pkg::ST_SQ_M: begin
                if (alu_done) begin
                    sq_next    = {1'b0, s2_reg} - {1'b0, alu_prod[47:0]};
                    state_next = asc_pkg::ST_MUL_A;
                    pend_next  = 1'b1;
                end
            end
            asc_pkg::ST_MUL_A: begin
                if (alu_done) begin
                    a_next     = alu_prod[63:0];
                    state_next = asc_pkg::ST_MUL_B;
                    pend_next  = 1'b1;
                end
            end
            asc_pkg::ST_MUL_B: begin
                if (alu_done) begin
                    b_next     = alu_prod[34:0];
                    state_next = asc_pkg::ST_MUL_AB;
                    pend_next  = 1'b1;
                end
            end
            asc_pkg::ST_MUL_AB: begin
                if (alu_done) begin
                    // a*b > d<<32, same signs, neither term zero
                    if ((a_reg != 64'd0) && (b_reg != 35'd0) &&
                        (sq_reg[48] == dr_reg[18]) && (alu_prod > dev_lim)) begin
                        edge_next     = 1'b1;
                        out_curb_next = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    state_next     = asc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = asc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_limit_reg <= '0;
            dev_weight_reg  <= 16'd256;
            dist_weight_reg <= 16'd256;
            min_points_reg  <= 10'd10;
        end else if (cfg_wr_en) begin
            unique case (asc_pkg::cfg_reg_t'(cfg_index))
                asc_pkg::CFG_SLOPE_LIMIT: slope_limit_reg <= cfg_wdata;
                asc_pkg::CFG_DEV_WEIGHT:  dev_weight_reg  <= cfg_wdata[15:0];
                asc_pkg::CFG_DIST_WEIGHT: dist_weight_reg <= cfg_wdata[15:0];
                asc_pkg::CFG_MIN_POINTS:  min_points_reg  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= asc_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            prev_r_reg    <= '0;
            prev_h_reg    <= '0;
            mean_reg      <= '0;
            dev_reg       <= '0;
            index_reg     <= '0;
            invalid_reg   <= '0;
            edge_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            prev_r_reg    <= prev_r_next;
            prev_h_reg    <= prev_h_next;
            mean_reg      <= mean_next;
            dev_reg       <= dev_next;
            index_reg     <= index_next;
            invalid_reg   <= invalid_next;
            edge_reg      <= edge_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dz_reg       <= dz_next;
        dr_reg       <= dr_next;
        s_reg        <= s_next;
        t_reg        <= t_next;
        diff_reg     <= diff_next;
        s2_reg       <= s2_next;
        sq_reg       <= sq_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        out_curb_reg <= out_curb_next;
        out_idx_reg  <= out_idx_next;
    end

endmodule
